[sv/tmp_pkg.sv]
// Package for the tape memory with pointer: operation codes, register
// indexes, field widths and cell width masks. No dependencies.
package tmp_pkg;

	// Field widths fixed by the interface
	localparam int OP_W    = 4;
	localparam int ADDR_W  = 12;
	localparam int VALUE_W = 32;
	localparam int PTR_W   = 12;
	localparam int LEN_W   = 13;
	localparam int MODE_W  = 2;
	localparam int CFGI_W  = 2;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_LEFT       = 4'd0,
		OP_RIGHT      = 4'd1,
		OP_INC        = 4'd2,
		OP_DEC        = 4'd3,
		OP_WRITE_CUR  = 4'd4,
		OP_READ_CUR   = 4'd5,
		OP_WRITE_ADDR = 4'd6,
		OP_READ_ADDR  = 4'd7,
		OP_CLEAR      = 4'd8
	} op_t;

	// Configuration register indexes
	typedef enum logic [CFGI_W-1:0] {
		CFG_CELL_WIDTH   = 2'd0,
		CFG_POINTER_WRAP = 2'd1,
		CFG_TAPE_LENGTH  = 2'd2
	} cfg_idx_t;

	// Cell width modes
	localparam logic [MODE_W-1:0] MODE_8  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_16 = 2'd1;

	localparam logic [VALUE_W-1:0] MASK_8  = 32'h0000_00FF;
	localparam logic [VALUE_W-1:0] MASK_16 = 32'h0000_FFFF;
	localparam logic [VALUE_W-1:0] MASK_32 = 32'hFFFF_FFFF;

	localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

endpackage

[sv/tape_memory_with_pointer.sv]
// Top level of the tape memory with pointer: head register, cell RAM,
// read-modify-write stage and result register. Uses tmp_pkg and tmp_ram.
//
// Usage: each request on the input channel (op, address, value) carries one
// tape operation; each produces exactly one result (pointer, cell_value) on
// the output channel, in order. The config channel writes cell_width_mode,
// pointer_wrap and tape_length by index; it is always ready.
// Path: an accepted request is read from the cell RAM into its registered
// read data as it enters the modify stage; when that stage advances, the
// cell is written back and the result is loaded into the output register.
// Throughput is one request per cycle while the output does not stall and no
// sweep runs, set by the single read-modify-write pass over the RAM; a write
// followed at once by a request to the same cell is served from a forwarding
// register. A clear request returns its result without waiting for the sweep,
// and blocks the input while a sweep zeroes the RAM one cell a cycle.
// Reset: the head goes to zero, registers to their defaults, and the same
// zeroing sweep runs before the first request is taken.
// Stall: when out_ready is low the result is held; one more request may be
// taken into the modify stage, after which in_ready drops until the
// result register drains.
module tape_memory_with_pointer #(
	parameter int TAPE_DEPTH = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tmp_pkg::OP_W-1:0]    op,
	input  logic [tmp_pkg::ADDR_W-1:0]  address,
	input  logic [tmp_pkg::VALUE_W-1:0] value,
	// Result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tmp_pkg::PTR_W-1:0]   pointer,
	output logic [tmp_pkg::VALUE_W-1:0] cell_value,
	// Configuration channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tmp_pkg::CFGI_W-1:0]  cfg_index,
	input  logic [tmp_pkg::VALUE_W-1:0] cfg_data
);

	import tmp_pkg::*;

	localparam int AW      = $clog2(TAPE_DEPTH);
	localparam int MAX_LEN = (TAPE_DEPTH < 8191) ? TAPE_DEPTH : 8191;
	localparam int HEAD_W  = $clog2(MAX_LEN);

	// Configuration registers
	logic [MODE_W-1:0] width_mode_q;
	logic              wrap_q;
	logic [LEN_W-1:0]  tape_len_q;

	// Control state
	logic              head_q_valid_unused;
	logic [HEAD_W-1:0] head_q;
	logic              sweep_q;
	logic [AW-1:0]     sweep_cnt_q;
	logic              s1_valid_q;
	logic              out_valid_q;
	logic              fwd_valid_q;

	// Modify stage payload
	op_t                s1_op_s1;
	logic [AW-1:0]      idx_s1;
	logic               ok_s1;
	logic [VALUE_W-1:0] val_s1;
	logic [HEAD_W-1:0]  head_s1;

	// Forwarding and result payload
	logic [AW-1:0]      fwd_idx_q;
	logic [VALUE_W-1:0] fwd_data_q;
	logic [PTR_W-1:0]   pointer_q;
	logic [VALUE_W-1:0] cell_value_q;

	// Combinational signals
	op_t                in_op;
	logic               in_acc;
	logic               s1_adv;
	logic [LEN_W-1:0]   eff_len;
	logic [LEN_W-1:0]   len_m1;
	logic [LEN_W-1:0]   head_ext;
	logic [HEAD_W-1:0]  head_next;
	logic [AW-1:0]      rd_idx;
	logic               rd_ok;
	logic [VALUE_W-1:0] ram_rdata;
	logic [VALUE_W-1:0] cell_old;
	logic [VALUE_W-1:0] cell_new;
	logic [VALUE_W-1:0] shown;
	logic [VALUE_W-1:0] mask;
	logic               s1_we;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [VALUE_W-1:0] ram_wdata;

	assign head_q_valid_unused = 1'b0;
	assign in_op     = op_t'(op);
	assign cfg_ready = 1'b1;
	assign s1_adv    = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready  = !sweep_q && (!s1_valid_q || s1_adv) && !head_q_valid_unused;
	assign in_acc    = in_valid && in_ready;

	// Effective tape length and last reachable cell
	always_comb begin
		if (tape_len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (32'(tape_len_q) > 32'(TAPE_DEPTH)) begin
			eff_len = LEN_W'(TAPE_DEPTH);
		end else begin
			eff_len = tape_len_q;
		end
		len_m1   = eff_len - LEN_W'(1);
		head_ext = LEN_W'(head_q);
	end

	// Advance the head and pick the cell to read
	always_comb begin
		head_next = head_q;
		unique case (in_op)
			OP_LEFT: begin
				if (head_q != '0) begin
					head_next = head_q - HEAD_W'(1);
				end else if (wrap_q) begin
					head_next = HEAD_W'(len_m1);
				end
			end
			OP_RIGHT: begin
				if (head_ext < len_m1) begin
					head_next = head_q + HEAD_W'(1);
				end else if (wrap_q) begin
					head_next = '0;
				end else begin
					head_next = HEAD_W'(len_m1);
				end
			end
			OP_CLEAR: head_next = '0;
			default:  head_next = head_q;
		endcase

		if (in_op == OP_WRITE_ADDR || in_op == OP_READ_ADDR) begin
			rd_idx = AW'(address);
			rd_ok  = 32'(address) < 32'(TAPE_DEPTH);
		end else begin
			rd_idx = AW'(head_next);
			rd_ok  = 1'b1;
		end
	end

	// Cell width mask
	always_comb begin
		unique case (width_mode_q)
			MODE_8:  mask = MASK_8;
			MODE_16: mask = MASK_16;
			default: mask = MASK_32;
		endcase
	end

	// Modify the cell: forward the last write when it targets the same cell
	always_comb begin
		if (fwd_valid_q && fwd_idx_q == idx_s1) begin
			cell_old = fwd_data_q;
		end else begin
			cell_old = ram_rdata;
		end
		if (!ok_s1) begin
			cell_old = '0;
		end

		cell_new = cell_old;
		s1_we    = 1'b0;
		unique case (s1_op_s1)
			OP_INC: begin
				cell_new = (cell_old + VALUE_W'(1)) & mask;
				s1_we    = 1'b1;
			end
			OP_DEC: begin
				cell_new = (cell_old - VALUE_W'(1)) & mask;
				s1_we    = 1'b1;
			end
			OP_WRITE_CUR, OP_WRITE_ADDR: begin
				cell_new = val_s1 & mask;
				s1_we    = ok_s1;
			end
			OP_CLEAR: cell_new = '0;
			default:  cell_new = cell_old;
		endcase
		shown = s1_we ? cell_new : cell_old;
		if (s1_op_s1 == OP_CLEAR) begin
			shown = '0;
		end
	end

	// Share the write port between the zeroing sweep and the modify stage
	always_comb begin
		if (sweep_q) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = s1_adv && s1_we;
			ram_waddr = idx_s1;
			ram_wdata = cell_new;
		end
	end

	tmp_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(TAPE_DEPTH)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (in_acc),
		.raddr(rd_idx),
		.rdata(ram_rdata)
	);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_mode_q <= MODE_8;
			wrap_q       <= 1'b0;
			tape_len_q   <= LEN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CELL_WIDTH:   width_mode_q <= cfg_data[MODE_W-1:0];
				CFG_POINTER_WRAP: wrap_q       <= cfg_data[0];
				CFG_TAPE_LENGTH:  tape_len_q   <= cfg_data[LEN_W-1:0];
				default:          ;
			endcase
		end
	end

	// Hold the head, run the zeroing sweep, track stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				head_q <= head_next;
			end

			if (sweep_q) begin
				sweep_cnt_q <= sweep_cnt_q + AW'(1);
				if (32'(sweep_cnt_q) == TAPE_DEPTH - 1) begin
					sweep_q <= 1'b0;
				end
			end else if (in_acc && in_op == OP_CLEAR) begin
				sweep_q     <= 1'b1;
				sweep_cnt_q <= '0;
			end

			if (in_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end

			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (sweep_q) begin
				fwd_valid_q <= 1'b0;
			end else if (s1_adv) begin
				fwd_valid_q <= s1_we;
			end
		end
	end

	// Capture the request into the modify stage
	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_op_s1 <= in_op;
			idx_s1   <= rd_idx;
			ok_s1    <= rd_ok;
			val_s1   <= value;
			head_s1  <= head_next;
		end
	end

	// Load the result register and the forwarding register
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pointer_q    <= PTR_W'(head_s1);
			cell_value_q <= shown;
			fwd_idx_q    <= idx_s1;
			fwd_data_q   <= cell_new;
		end
	end

	assign out_valid  = out_valid_q;
	assign pointer    = pointer_q;
	assign cell_value = cell_value_q;

endmodule

[sv/tmp_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered
// read data. Read data updates only when the read is enabled. No dependencies.
module tmp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and register the read data (old contents on a same-address hit)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
